FILE: hdl/pfca_pkg.sv
// Package for the polygon face centroid and area block.
// Holds widths, the sequencer state type, the iteration unit command and
// the saturation helper. Depends on nothing.
package pfca_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int NRM_W   = 35;
    localparam int NSUM_W  = 40;
    localparam int ROOT_W  = 36;
    localparam int ASUM_W  = 41;
    localparam int WSUM_W  = 58;
    localparam int SQ_W    = 72;
    localparam int MUL_W   = 36;
    localparam int DVD_W   = 58;
    localparam int DVS_W   = 43;
    localparam int REM_W   = 60;
    localparam int STEP_W  = 6;

    localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd36;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd58;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SQST,
        S_SQRT,
        S_WMUL,
        S_FIN,
        S_DIV,
        S_DIVW,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } iter_cmd_t;

    function automatic logic [COORD_W-1:0] sat_q(input logic neg,
                                                input logic [DVD_W-1:0] q);
        logic [DVD_W-1:0] nq;
        nq = ~q + 1'b1;
        if (neg)
        begin
            if (q > 58'd32768)
                return 16'h8000;
            else
                return nq[COORD_W-1:0];
        end
        else
        begin
            if (q > 58'd32767)
                return 16'h7FFF;
            else
                return q[COORD_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/pfca_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pfca_pkg.
module pfca_mul
(
    input  logic                                  clk,
    input  logic signed [pfca_pkg::MUL_W-1:0]     a,
    input  logic signed [pfca_pkg::MUL_W-1:0]     b,
    output logic signed [2*pfca_pkg::MUL_W-1:0]   p
);

    logic signed [2*pfca_pkg::MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: hdl/pfca_iter.sv
// Shared iteration unit: restoring square root (two bits a step) and
// restoring division (one bit a step) over one subtractor.
// Depends on pfca_pkg.
module pfca_iter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfca_pkg::iter_cmd_t           cmd,
    input  logic [pfca_pkg::SQ_W-1:0]     src,
    input  logic [pfca_pkg::DVS_W-1:0]    dvs,
    output logic                          busy,
    output logic                          done,
    output logic [pfca_pkg::DVD_W-1:0]    res
);

    logic [pfca_pkg::SQ_W-1:0]   src_reg;
    logic [pfca_pkg::DVS_W-1:0]  dvs_reg;
    logic [pfca_pkg::REM_W-1:0]  rem_reg;
    logic [pfca_pkg::DVD_W-1:0]  res_reg;
    logic [pfca_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        mode_reg;

    logic [pfca_pkg::REM_W-1:0]  shifted;
    logic [pfca_pkg::REM_W-1:0]  trial;
    logic [pfca_pkg::REM_W:0]    diff;
    logic                        ge;

    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[pfca_pkg::REM_W-3:0], src_reg[pfca_pkg::SQ_W-1 -: 2]};
            trial   = {res_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[pfca_pkg::REM_W-2:0], src_reg[pfca_pkg::SQ_W-1]};
            trial   = {{(pfca_pkg::REM_W-pfca_pkg::DVS_W){1'b0}}, dvs_reg};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[pfca_pkg::REM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            res_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            src_reg  <= src;
            dvs_reg  <= dvs;
            rem_reg  <= '0;
            res_reg  <= '0;
            mode_reg <= cmd.sqrt_mode;
            cnt_reg  <= cmd.sqrt_mode ? pfca_pkg::SQRT_STEPS : pfca_pkg::DIV_STEPS;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[pfca_pkg::REM_W-1:0] : shifted;
            res_reg <= {res_reg[pfca_pkg::DVD_W-2:0], ge};
            src_reg <= mode_reg ? {src_reg[pfca_pkg::SQ_W-3:0], 2'b00}
                                : {src_reg[pfca_pkg::SQ_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: hdl/polygon_face_centroid_area.sv
// Polygon face centroid and area vector over a triangle fan.
// A first or second vertex is only stored and summed; each later vertex runs
// nine multiplies on the shared multiplier, a 36-step square root and three
// weighting multiplies. A last vertex adds three 58-step divisions in the
// shared iteration unit before the result item.
// Reset clears all face state and sets min_area to 1.
module polygon_face_centroid_area
#(
    parameter int MAX_VERTS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // vert_x, vert_y, vert_z
    input  logic         s_tlast,   // last_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // center_x, center_y, center_z, area_x, area_y, area_z
    output logic [1:0]   m_tuser,   // degenerate, too_many_vertices
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_VERTS + 1);
    localparam int CS_W  = 17 + $clog2(MAX_VERTS);

    pfca_pkg::state_t state_reg, state_next;

    logic signed [15:0] in_p [3];
    logic signed [15:0] p_reg [3];
    logic signed [15:0] first_reg [3];
    logic signed [15:0] prev_reg [3];
    logic signed [CS_W-1:0] csum_reg [3];
    logic signed [pfca_pkg::NSUM_W-1:0] nsum_reg [3];
    logic signed [pfca_pkg::WSUM_W-1:0] wsum_reg [3];
    logic signed [pfca_pkg::NRM_W-1:0] n_reg [3];
    logic signed [pfca_pkg::NRM_W-1:0] t_reg;
    logic signed [15:0] cen_reg [3];
    logic [pfca_pkg::ASUM_W-1:0] asum_reg;
    logic [pfca_pkg::SQ_W-1:0] ssum_reg;
    logic [pfca_pkg::ROOT_W-1:0] a_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0] min_area_reg;
    logic [3:0] k_reg;
    logic [1:0] axis_reg;
    logic last_reg, ovf_reg, degen_reg, neg_reg;
    logic m_tvalid_reg;
    logic [167:0] m_tdata_reg;
    logic [1:0] m_tuser_reg;

    logic signed [pfca_pkg::DIFF_W-1:0] u [3];
    logic signed [pfca_pkg::DIFF_W-1:0] v [3];
    logic signed [17:0] tc [3];
    logic signed [pfca_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [2*pfca_pkg::MUL_W-1:0] prod;
    logic signed [pfca_pkg::DVD_W-1:0] dsig;
    logic [pfca_pkg::DVD_W-1:0] dmag;
    logic [pfca_pkg::DVS_W-1:0] dvs;
    logic [CNT_W-1:0] cnt_div;
    logic [pfca_pkg::SQ_W-1:0] iter_src;
    logic [pfca_pkg::DVD_W-1:0] iter_res;
    logic iter_busy, iter_done;
    pfca_pkg::iter_cmd_t cmd;
    logic accept;
    logic [1:0] widx;

    function automatic logic signed [pfca_pkg::MUL_W-1:0] ext17(
        input logic signed [pfca_pkg::DIFF_W-1:0] x);
        return {{(pfca_pkg::MUL_W-pfca_pkg::DIFF_W){x[pfca_pkg::DIFF_W-1]}}, x};
    endfunction

    function automatic logic signed [pfca_pkg::MUL_W-1:0] ext35(
        input logic signed [pfca_pkg::NRM_W-1:0] x);
        return {{(pfca_pkg::MUL_W-pfca_pkg::NRM_W){x[pfca_pkg::NRM_W-1]}}, x};
    endfunction

    function automatic logic signed [pfca_pkg::MUL_W-1:0] MUL_Wext18(
        input logic signed [17:0] x);
        return {{(pfca_pkg::MUL_W-18){x[17]}}, x};
    endfunction

    assign in_p[0] = s_tdata[15:0];
    assign in_p[1] = s_tdata[31:16];
    assign in_p[2] = s_tdata[47:32];
    assign s_tready = (state_reg == pfca_pkg::S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign widx = 2'(k_reg - 4'd1);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i]  = {prev_reg[i][15], prev_reg[i]} - {first_reg[i][15], first_reg[i]};
            v[i]  = {p_reg[i][15], p_reg[i]} - {first_reg[i][15], first_reg[i]};
            tc[i] = {{2{first_reg[i][15]}}, first_reg[i]} + {{2{prev_reg[i][15]}}, prev_reg[i]}
                  + {{2{p_reg[i][15]}}, p_reg[i]};
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == pfca_pkg::S_WMUL)
        begin
            mul_a = signed'(a_reg);
            case (k_reg)
                4'd0:    mul_b = MUL_Wext18(tc[0]);
                4'd1:    mul_b = MUL_Wext18(tc[1]);
                default: mul_b = MUL_Wext18(tc[2]);
            endcase
        end
        else
        begin
            case (k_reg)
                4'd0:    begin mul_a = ext17(u[1]); mul_b = ext17(v[2]); end
                4'd1:    begin mul_a = ext17(u[2]); mul_b = ext17(v[1]); end
                4'd2:    begin mul_a = ext17(u[2]); mul_b = ext17(v[0]); end
                4'd3:    begin mul_a = ext17(u[0]); mul_b = ext17(v[2]); end
                4'd4:    begin mul_a = ext17(u[0]); mul_b = ext17(v[1]); end
                4'd5:    begin mul_a = ext17(u[1]); mul_b = ext17(v[0]); end
                4'd6:    begin mul_a = ext35(n_reg[0]); mul_b = ext35(n_reg[0]); end
                4'd7:    begin mul_a = ext35(n_reg[1]); mul_b = ext35(n_reg[1]); end
                default: begin mul_a = ext35(n_reg[2]); mul_b = ext35(n_reg[2]); end
            endcase
        end
    end

    pfca_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        cnt_div = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        if (degen_reg)
        begin
            dsig = {{(pfca_pkg::DVD_W-CS_W){csum_reg[axis_reg][CS_W-1]}}, csum_reg[axis_reg]};
            dvs  = {{(pfca_pkg::DVS_W-CNT_W){1'b0}}, cnt_div};
        end
        else
        begin
            dsig = wsum_reg[axis_reg];
            dvs  = {1'b0, asum_reg, 1'b0} + {2'b00, asum_reg};
        end
        dmag = dsig[pfca_pkg::DVD_W-1] ? 58'(-dsig) : 58'(dsig);
        cmd.start     = (state_reg == pfca_pkg::S_SQST) || (state_reg == pfca_pkg::S_DIV);
        cmd.sqrt_mode = (state_reg == pfca_pkg::S_SQST);
        iter_src = cmd.sqrt_mode ? ssum_reg
                                 : {dmag, {(pfca_pkg::SQ_W-pfca_pkg::DVD_W){1'b0}}};
    end

    pfca_iter u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .src   (iter_src),
        .dvs   (dvs),
        .busy  (iter_busy),
        .done  (iter_done),
        .res   (iter_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_reg >= CNT_W'(MAX_VERTS) || cnt_reg < CNT_W'(2))
                        state_next = s_tlast ? pfca_pkg::S_FIN : pfca_pkg::S_IDLE;
                    else
                        state_next = pfca_pkg::S_MUL;
                end
            end
            pfca_pkg::S_MUL:
            begin
                if (k_reg == 4'd9)
                    state_next = pfca_pkg::S_SQST;
            end
            pfca_pkg::S_SQST: state_next = pfca_pkg::S_SQRT;
            pfca_pkg::S_SQRT:
            begin
                if (iter_done)
                    state_next = pfca_pkg::S_WMUL;
            end
            pfca_pkg::S_WMUL:
            begin
                if (k_reg == 4'd3)
                    state_next = last_reg ? pfca_pkg::S_FIN : pfca_pkg::S_IDLE;
            end
            pfca_pkg::S_FIN: state_next = pfca_pkg::S_DIV;
            pfca_pkg::S_DIV: state_next = pfca_pkg::S_DIVW;
            pfca_pkg::S_DIVW:
            begin
                if (iter_done)
                    state_next = (axis_reg == 2'd2) ? pfca_pkg::S_EMIT : pfca_pkg::S_DIV;
            end
            pfca_pkg::S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = pfca_pkg::S_IDLE;
            end
            default: state_next = pfca_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfca_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i]     <= '0;
                first_reg[i] <= '0;
                prev_reg[i]  <= '0;
                csum_reg[i]  <= '0;
                nsum_reg[i]  <= '0;
                wsum_reg[i]  <= '0;
                n_reg[i]     <= '0;
                cen_reg[i]   <= '0;
            end
            t_reg        <= '0;
            asum_reg     <= '0;
            ssum_reg     <= '0;
            a_reg        <= '0;
            cnt_reg      <= '0;
            min_area_reg <= 32'd1;
            k_reg        <= '0;
            axis_reg     <= '0;
            last_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            degen_reg    <= 1'b0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            if (cfg_wen)
                min_area_reg <= cfg_wdata;
            if (m_tvalid_reg && m_tready && state_reg != pfca_pkg::S_EMIT)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                pfca_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        for (int i = 0; i < 3; i++)
                            p_reg[i] <= in_p[i];
                        last_reg <= s_tlast;
                        ssum_reg <= '0;
                        k_reg    <= '0;
                        if (cnt_reg >= CNT_W'(MAX_VERTS))
                            ovf_reg <= 1'b1;
                        else if (cnt_reg < CNT_W'(2))
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                if (cnt_reg == '0)
                                    first_reg[i] <= in_p[i];
                                prev_reg[i] <= in_p[i];
                                csum_reg[i] <= csum_reg[i]
                                    + {{(CS_W-16){in_p[i][15]}}, in_p[i]};
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                pfca_pkg::S_MUL:
                begin
                    k_reg <= k_reg + 1'b1;
                    case (k_reg)
                        4'd1, 4'd3, 4'd5: t_reg <= prod[pfca_pkg::NRM_W-1:0];
                        4'd2: n_reg[0] <= t_reg - prod[pfca_pkg::NRM_W-1:0];
                        4'd4: n_reg[1] <= t_reg - prod[pfca_pkg::NRM_W-1:0];
                        4'd6: n_reg[2] <= t_reg - prod[pfca_pkg::NRM_W-1:0];
                        4'd7, 4'd8, 4'd9: ssum_reg <= ssum_reg + prod;
                        default: ;
                    endcase
                end
                pfca_pkg::S_SQRT:
                begin
                    k_reg <= '0;
                    if (iter_done)
                        a_reg <= iter_res[pfca_pkg::ROOT_W-1:0];
                end
                pfca_pkg::S_WMUL:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg != 4'd0)
                        wsum_reg[widx] <= wsum_reg[widx]
                            + {{(pfca_pkg::WSUM_W-53){prod[52]}}, prod[52:0]};
                    if (k_reg == 4'd3)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            prev_reg[i] <= p_reg[i];
                            csum_reg[i] <= csum_reg[i] + {{(CS_W-16){p_reg[i][15]}}, p_reg[i]};
                            nsum_reg[i] <= nsum_reg[i]
                                + {{(pfca_pkg::NSUM_W-pfca_pkg::NRM_W){n_reg[i][pfca_pkg::NRM_W-1]}},
                                   n_reg[i]};
                        end
                        asum_reg <= asum_reg + {{(pfca_pkg::ASUM_W-pfca_pkg::ROOT_W){1'b0}}, a_reg};
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                pfca_pkg::S_FIN:
                begin
                    degen_reg <= (asum_reg == '0) || (asum_reg < {9'd0, min_area_reg});
                    axis_reg  <= '0;
                end
                pfca_pkg::S_DIV:
                begin
                    neg_reg <= dsig[pfca_pkg::DVD_W-1];
                end
                pfca_pkg::S_DIVW:
                begin
                    if (iter_done)
                    begin
                        cen_reg[axis_reg] <= pfca_pkg::sat_q(neg_reg, iter_res);
                        if (axis_reg != 2'd2)
                            axis_reg <= axis_reg + 1'b1;
                    end
                end
                pfca_pkg::S_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg[47:0] <= {cen_reg[2], cen_reg[1], cen_reg[0]};
                        m_tdata_reg[167:48] <= degen_reg ? '0
                                             : {nsum_reg[2], nsum_reg[1], nsum_reg[0]};
                        m_tuser_reg <= {ovf_reg, degen_reg};
                        for (int i = 0; i < 3; i++)
                        begin
                            first_reg[i] <= '0;
                            prev_reg[i]  <= '0;
                            csum_reg[i]  <= '0;
                            nsum_reg[i]  <= '0;
                            wsum_reg[i]  <= '0;
                        end
                        asum_reg <= '0;
                        cnt_reg  <= '0;
                        ovf_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A degenerate face always carries a zero area vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[167:48] == '0)
        else $error("degenerate face with non-zero area vector");

    // The iteration unit is never restarted while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !iter_busy)
        else $error("iteration unit started while busy");

    // The vertex count never passes the face limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTS))
        else $error("vertex count beyond limit");

    // A square root finishing always hands over to the weighting multiplies.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pfca_pkg::S_SQRT && iter_done |=> state_reg == pfca_pkg::S_WMUL)
        else $error("square root result not consumed");

endmodule

FILE: tb/sv/tb_polygon_face_centroid_area.sv
`timescale 1ns / 1ps
// Self-checking testbench for polygon_face_centroid_area: streams faces of vertices,
// predicts centroid, area vector and flags per face, and checks every result item.
// Depends on the block's RTL.
module tb_polygon_face_centroid_area;

    localparam int MAX_VERTS   = 16;
    localparam int SETTLE      = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 3000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } vertex_t;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [39:0] ax;
        logic [39:0] ay;
        logic [39:0] az;
        logic        degen;
        logic        too_many;
    } face_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wen;
    logic [31:0]  cfg_wdata;

    vertex_t      pending_verts[$];
    face_result_t face_results[$];
    int           errors;
    int           idle_cycles;
    int           tx_gap;
    int           rx_gap;
    int           hold_left;
    bit           in_taken;

    // Face accumulation state of the predictor.
    logic [31:0]  area_floor;
    longint       fan_first[3];
    longint       fan_prev[3];
    int           fan_count;
    longint       sum_coord[3];
    longint       sum_normal[3];
    longint       sum_area;
    longint       sum_weighted[3];
    bit           extra_verts;

    polygon_face_centroid_area #(.MAX_VERTS(MAX_VERTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [34:0] triangle_area(longint n0, longint n1, longint n2);
        logic [127:0] sq_sum;
        logic [127:0] m;
        logic [34:0]  r;
        logic [34:0]  t;
        sq_sum = 0;
        m = (n0 < 0) ? -n0 : n0;
        sq_sum += m * m;
        m = (n1 < 0) ? -n1 : n1;
        sq_sum += m * m;
        m = (n2 < 0) ? -n2 : n2;
        sq_sum += m * m;
        r = 0;
        for (int b = 34; b >= 0; b--)
        begin
            t = r | (35'd1 << b);
            if ((128'(t) * 128'(t)) <= sq_sum)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic void clear_face();
        for (int i = 0; i < 3; i++)
        begin
            fan_first[i]    = 0;
            fan_prev[i]     = 0;
            sum_coord[i]    = 0;
            sum_normal[i]   = 0;
            sum_weighted[i] = 0;
        end
        fan_count   = 0;
        sum_area    = 0;
        extra_verts = 0;
    endfunction

    function automatic void add_vertex(vertex_t vin);
        longint       p[3];
        longint       u[3];
        longint       v[3];
        longint       n[3];
        longint       a;
        longint       cnt;
        longint       den;
        face_result_t res;
        p[0] = vin.x;
        p[1] = vin.y;
        p[2] = vin.z;
        if (fan_count >= MAX_VERTS)
            extra_verts = 1;
        else
        begin
            if (fan_count == 0)
                for (int i = 0; i < 3; i++)
                    fan_first[i] = p[i];
            else if (fan_count >= 2)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    u[i] = fan_prev[i] - fan_first[i];
                    v[i] = p[i] - fan_first[i];
                end
                n[0] = u[1] * v[2] - u[2] * v[1];
                n[1] = u[2] * v[0] - u[0] * v[2];
                n[2] = u[0] * v[1] - u[1] * v[0];
                a = triangle_area(n[0], n[1], n[2]);
                for (int i = 0; i < 3; i++)
                begin
                    sum_normal[i]   += n[i];
                    sum_weighted[i] += a * (fan_first[i] + fan_prev[i] + p[i]);
                end
                sum_area += a;
            end
            for (int i = 0; i < 3; i++)
            begin
                fan_prev[i]  = p[i];
                sum_coord[i] += p[i];
            end
            fan_count++;
        end
        if (!vin.last)
            return;
        if (sum_area == 0 || sum_area < longint'({32'd0, area_floor}))
        begin
            cnt = (fan_count != 0) ? fan_count : 1;
            res.cx = clamp16(sum_coord[0] / cnt);
            res.cy = clamp16(sum_coord[1] / cnt);
            res.cz = clamp16(sum_coord[2] / cnt);
            res.ax = 0;
            res.ay = 0;
            res.az = 0;
            res.degen = 1;
        end
        else
        begin
            den = 3 * sum_area;
            res.cx = clamp16(sum_weighted[0] / den);
            res.cy = clamp16(sum_weighted[1] / den);
            res.cz = clamp16(sum_weighted[2] / den);
            res.ax = sum_normal[0][39:0];
            res.ay = sum_normal[1][39:0];
            res.az = sum_normal[2][39:0];
            res.degen = 0;
        end
        res.too_many = extra_verts;
        face_results.push_back(res);
        clear_face();
    endfunction

    function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
                $display("Mismatch in %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // Input side: accepted items feed the predictor.
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            add_vertex('{s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tlast});
    end

    // Output side: each result item is compared with the oldest expectation.
    always @(posedge clk)
    begin
        face_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (face_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result item: tdata %h tuser %b", m_tdata, m_tuser);
            end
            else
            begin
                want = face_results.pop_front();
                check_field("center_x", 40'(want.cx), 40'(m_tdata[15:0]));
                check_field("center_y", 40'(want.cy), 40'(m_tdata[31:16]));
                check_field("center_z", 40'(want.cz), 40'(m_tdata[47:32]));
                check_field("area_x", want.ax, m_tdata[87:48]);
                check_field("area_y", want.ay, m_tdata[127:88]);
                check_field("area_z", want.az, m_tdata[167:128]);
                check_field("degenerate", 40'(want.degen), 40'(m_tuser[0]));
                check_field("too_many_vertices", 40'(want.too_many), 40'(m_tuser[1]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge clk)
    begin
        vertex_t vin;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !in_taken)
            s_tvalid <= 1'b1;
        else if (tx_gap > 0)
        begin
            tx_gap <= tx_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (pending_verts.size() > 0)
        begin
            vin = pending_verts.pop_front();
            s_tdata  <= {vin.z, vin.y, vin.x};
            s_tlast  <= vin.last;
            s_tvalid <= 1'b1;
            tx_gap   <= random_gap();
        end
        else
            s_tvalid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap <= rx_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (m_tvalid)
                rx_gap <= random_gap();
        end
    end

    function automatic logic signed [15:0] rand_coord(bit narrow);
        if (narrow)
            return 16'($signed($urandom_range(0, 4095)) - 2048);
        return 16'($urandom);
    endfunction

    task automatic queue_face(int count, bit narrow);
        vertex_t vin;
        for (int i = 0; i < count; i++)
        begin
            vin.x = rand_coord(narrow);
            vin.y = rand_coord(narrow);
            vin.z = rand_coord(narrow);
            vin.last = (i == count - 1);
            pending_verts.push_back(vin);
        end
    endtask

    task automatic queue_vertex(int x, int y, int z, bit last);
        pending_verts.push_back('{16'(x), 16'(y), 16'(z), last});
    endtask

    task automatic drain();
        wait (pending_verts.size() == 0 && !s_tvalid && face_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_min_area(logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        area_floor = value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic queue_random_faces(int n_items);
        int added;
        int len;
        added = 0;
        while (added < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
                len = $urandom_range(3, 8);
            else
                len = $urandom_range(1, 20);
            queue_face(len, $urandom_range(0, 1));
            added += len;
        end
    endtask

    initial
    begin
        logic [31:0] levels[4];
        errors     = 0;
        tx_gap     = 0;
        rx_gap     = 0;
        hold_left  = 0;
        in_taken   = 0;
        idle_cycles = 0;
        area_floor = 32'd1;
        clear_face();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed faces: extremes, short faces, a flat face and an overlong face.
        queue_vertex(-32768, -32768, -32768, 0);
        queue_vertex(32767, -32768, 32767, 0);
        queue_vertex(-32768, 32767, 32767, 1);
        queue_vertex(32767, 32767, 32767, 1);
        queue_vertex(-32768, 0, 256, 0);
        queue_vertex(256, -32768, 0, 1);
        queue_vertex(0, 0, 0, 0);
        queue_vertex(256, 256, 256, 0);
        queue_vertex(512, 512, 512, 1);
        queue_vertex(0, 0, 0, 0);
        queue_vertex(256, 0, 0, 0);
        queue_vertex(256, 256, 0, 0);
        queue_vertex(0, 256, 0, 1);
        queue_face(MAX_VERTS + 2, 1);
        drain();

        // Long receiver hold while the sender keeps offering.
        queue_random_faces(60);
        @(posedge clk);
        hold_left = LONG_HOLD;
        drain();

        levels[0] = 32'd0;
        levels[1] = 32'hFFFF_FFFF;
        levels[2] = 32'h0001_0000;
        levels[3] = $urandom;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_min_area(levels[ph]);
            queue_random_faces(75);
            drain();
            queue_random_faces(75);
        end
        set_min_area(32'd1);
        queue_random_faces(100);
        drain();

        if (face_results.size() != 0)
            errors++;
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pfca_pkg.sv
hdl/pfca_mul.sv
hdl/pfca_iter.sv
hdl/polygon_face_centroid_area.sv
tb/sv/tb_polygon_face_centroid_area.sv
